// ----- rtl/rf3_pkg.sv -----
// Shared types and constants of the 3x3 rank filter.
package rf3_pkg;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int WIDTH_REG_W = 11;
  localparam int ROW_W       = 12;
  localparam int MAX_HEIGHT  = 4096;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_PTR_W  = 4;
  localparam int FIFO_CNT_W  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FILTER_MODE  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_MEDIAN   = 2'd0,
    MODE_WINSOR   = 2'd1,
    MODE_WEIGHTED = 2'd2
  } mode_t;

endpackage

// ----- rtl/rf3_ram.sv -----
// Generic single-port-write, registered-read RAM that returns old data on a collision.
module rf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rf3_filter.sv -----
// Pipelined nine-value sort and mode selection of the 3x3 rank filter.
module rf3_filter #(
  parameter int PIXEL_BITS = 16,
  parameter int META_W     = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [PIXEL_BITS-1:0] in_win [9],
  input  logic [META_W-1:0]            in_meta,
  input  rf3_pkg::mode_t               mode,
  output logic                         out_valid,
  output logic [PIXEL_BITS-1:0]        out_value,
  output logic [META_W-1:0]            out_meta
);
  import rf3_pkg::*;

  localparam int SW    = PIXEL_BITS + 4;
  localparam int K     = PIXEL_BITS + 8;
  localparam int RW    = K - 3;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd9) / 64'd10);

  logic signed [PIXEL_BITS-1:0] st_r [10][9];
  logic signed [PIXEL_BITS-1:0] ctr_r [10];
  logic [META_W-1:0]            meta_r [10];
  logic                         v_r [10];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) begin
      st_r[0][j] <= in_win[j];
    end
    ctr_r[0]  <= in_win[4];
    meta_r[0] <= in_meta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 10; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      v_r[0] <= in_valid;
      for (int j = 1; j < 10; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  // Odd-even transposition sort: nine rounds, one register level each.
  for (genvar s = 0; s < 9; s++) begin : g_round
    localparam int FIRST = s % 2;
    logic signed [PIXEL_BITS-1:0] round_nxt [9];

    always_comb begin
      round_nxt = st_r[s];
      for (int p = FIRST; p < 8; p += 2) begin
        if (st_r[s][p] > st_r[s][p+1]) begin
          round_nxt[p]   = st_r[s][p+1];
          round_nxt[p+1] = st_r[s][p];
        end
      end
    end

    always_ff @(posedge clk) begin
      for (int j = 0; j < 9; j++) begin
        st_r[s+1][j] <= round_nxt[j];
      end
      ctr_r[s+1]  <= ctr_r[s];
      meta_r[s+1] <= meta_r[s];
    end
  end

  logic signed [SW-1:0]         sum;
  logic [SW-1:0]                mag;
  logic signed [PIXEL_BITS-1:0] sel;

  always_comb begin
    sum = SW'(st_r[9][2]) + SW'(st_r[9][6]) + (SW'(st_r[9][3]) <<< 1)
        + (SW'(st_r[9][5]) <<< 1) + (SW'(st_r[9][4]) <<< 2);
    mag = (sum < 0) ? SW'(-sum + SW'(5)) : SW'(sum + SW'(5));
    case (mode)
      MODE_WINSOR: begin
        if (ctr_r[9] < st_r[9][2]) begin
          sel = st_r[9][2];
        end else if (ctr_r[9] > st_r[9][6]) begin
          sel = st_r[9][6];
        end else begin
          sel = ctr_r[9];
        end
      end
      default: sel = st_r[9][4];
    endcase
  end

  logic                         s1_v_r, s2_v_r;
  logic [SW-1:0]                s1_mag_r;
  logic                         s1_neg_r, s2_neg_r;
  logic                         s1_wt_r, s2_wt_r;
  logic signed [PIXEL_BITS-1:0] s1_sel_r, s2_sel_r;
  logic [META_W-1:0]            s1_meta_r, s2_meta_r;
  logic [SW-1:0]                s2_q_r;
  logic [SW+RW-1:0]             prod;

  assign prod = (SW+RW)'(s1_mag_r) * (SW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= v_r[9];
      s2_v_r <= s1_v_r;
    end
    s1_mag_r  <= mag;
    s1_neg_r  <= sum < 0;
    s1_wt_r   <= mode == MODE_WEIGHTED;
    s1_sel_r  <= sel;
    s1_meta_r <= meta_r[9];
    s2_q_r    <= SW'(prod >> K);
    s2_neg_r  <= s1_neg_r;
    s2_wt_r   <= s1_wt_r;
    s2_sel_r  <= s1_sel_r;
    s2_meta_r <= s1_meta_r;
  end

  logic [SW-1:0] q_signed;
  assign q_signed  = s2_neg_r ? SW'(-s2_q_r) : s2_q_r;
  assign out_valid = s2_v_r;
  assign out_value = s2_wt_r ? q_signed[PIXEL_BITS-1:0] : s2_sel_r;
  assign out_meta  = s2_meta_r;

endmodule

// ----- rtl/rank_filter_3x3.sv -----
// Top level of the streaming 3x3 rank filter with line store and result queue.
// A result travels from stage B through the filter's sort registers and output registers into the result queue.
// Throughput: one item per cycle; an item that ends a row gives two results and holds the
// input while the window is extended by one replicated column.
// The input also stalls when fewer than two entries of the 16-entry result queue are left unreserved.
// Reset (synchronous, rst_n low) clears counters, window, queue and registers to defaults;
// the line store is not cleared and needs no clearing pass.
module rank_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rf3_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [PIXEL_BITS-1:0]        in_pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [PIXEL_BITS-1:0]        out_filtered_value,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_column,
  output logic [rf3_pkg::ROW_W-1:0]           out_row,
  output logic                                out_frame_done,
  output logic                                out_last_of_item
);
  import rf3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int META_W = COL_W + ROW_W + 2;
  localparam int FW     = PIXEL_BITS + META_W;

  // Configuration registers.
  logic [WIDTH_REG_W-1:0] width_r;
  logic [CFG_DATA_W-1:0]  height_r;
  mode_t                  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_W'(1024);
      height_r <= CFG_DATA_W'(1024);
      mode_r   <= MODE_MEDIAN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_FILTER_MODE:  mode_r   <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range.
  logic [CFG_DATA_W:0] eff_w, eff_h;
  logic [COL_W-1:0]    last_col;
  logic [ROW_W-1:0]    last_row;

  always_comb begin
    eff_w = (CFG_DATA_W+1)'(width_r);
    if (eff_w < (CFG_DATA_W+1)'(3)) eff_w = (CFG_DATA_W+1)'(3);
    if (eff_w > (CFG_DATA_W+1)'(MAX_WIDTH)) eff_w = (CFG_DATA_W+1)'(MAX_WIDTH);
    eff_h = (CFG_DATA_W+1)'(height_r);
    if (eff_h < (CFG_DATA_W+1)'(3)) eff_h = (CFG_DATA_W+1)'(3);
    if (eff_h > (CFG_DATA_W+1)'(MAX_HEIGHT)) eff_h = (CFG_DATA_W+1)'(MAX_HEIGHT);
    last_col = COL_W'(eff_w - 1'b1);
    last_row = ROW_W'(eff_h - 1'b1);
  end

  // Position counters. The flush counter holds the flush column plus one, zero when idle.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W:0]   flush_r, flush_nxt;

  // Stage B holds the item whose line-store reads are in flight.
  logic                         b_valid_r, b_valid_nxt, b_second_r, b_second_nxt;
  logic                         b_pix_r, b_par_r, b_low_r, b_load_r, b_triple_r;
  logic                         b_e1_r, b_e2_r;
  logic signed [PIXEL_BITS-1:0] b_px_r;
  logic [COL_W-1:0]             b_col1_r, b_col2_r;
  logic [ROW_W-1:0]             b_row_r;

  logic [FIFO_CNT_W-1:0] occ_r, occ_nxt;
  logic                  out_xfer;

  // Stage A: decode the item, move the counters and address the line store.
  logic             in_xfer, a_go, pend;
  logic [COL_W-1:0] k_col, idx;
  logic             a_load, a_e1, a_e2;
  logic [ROW_W-1:0] a_row;
  logic [1:0]       a_n;

  assign in_stall = (b_valid_r && !b_second_r && b_e2_r)
                 || (occ_r > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_xfer  = in_valid && !in_stall;
  assign pend     = flush_r != '0;
  assign k_col    = COL_W'(flush_r - 1'b1);
  assign idx      = in_command ? k_col : col_r;
  assign a_go     = in_xfer && (in_command ? pend : !pend);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    if (in_command) begin
      a_load = 1'b1;
      a_e1   = k_col != '0;
      a_e2   = k_col >= last_col;
      a_row  = row_r;
    end else begin
      a_load = row_r != '0;
      a_e1   = a_load && (col_r != '0);
      a_e2   = a_load && (col_r >= last_col);
      a_row  = row_r - 1'b1;
    end
    if (a_go) begin
      if (in_command) begin
        if (a_e2) begin
          flush_nxt = '0;
          row_nxt   = '0;
          col_nxt   = '0;
        end else begin
          flush_nxt = flush_r + 1'b1;
        end
      end else if (col_r >= last_col) begin
        col_nxt = '0;
        if (row_r >= last_row) begin
          flush_nxt = (COL_W+1)'(1);
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    a_n = a_go ? (2'(a_e1) + 2'(a_e2)) : 2'd0;
  end

  // The two previous rows live in two banks chosen by row parity.
  logic [PIXEL_BITS-1:0] d0, d1;

  rf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk   (clk),
    .we    (a_go && !in_command && !row_r[0]),
    .waddr (idx),
    .wdata (in_pixel_value),
    .raddr (idx),
    .rdata (d0)
  );

  rf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk   (clk),
    .we    (a_go && !in_command && row_r[0]),
    .waddr (idx),
    .wdata (in_pixel_value),
    .raddr (idx),
    .rdata (d1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      flush_r    <= '0;
      b_valid_r  <= 1'b0;
      b_second_r <= 1'b0;
      occ_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      flush_r    <= flush_nxt;
      b_valid_r  <= b_valid_nxt;
      b_second_r <= b_second_nxt;
      occ_r      <= occ_nxt;
    end
    if (a_go) begin
      b_pix_r    <= !in_command;
      b_par_r    <= row_r[0];
      b_low_r    <= row_r < ROW_W'(2);
      b_load_r   <= a_load;
      b_triple_r <= idx == '0;
      b_px_r     <= in_pixel_value;
      b_e1_r     <= a_e1;
      b_e2_r     <= a_e2;
      b_col1_r   <= idx - 1'b1;
      b_col2_r   <= idx;
      b_row_r    <= a_row;
    end
  end

  // Every accepted item reserves queue room for the results it will give.
  assign occ_nxt = occ_r + FIFO_CNT_W'(a_n) - FIFO_CNT_W'(out_xfer);

  // Stage B: build the new column, update the window and hand windows to the filter.
  logic signed [PIXEL_BITS-1:0] win_r [9];
  logic signed [PIXEL_BITS-1:0] win_nxt [9];
  logic signed [PIXEL_BITS-1:0] loaded [9];
  logic signed [PIXEL_BITS-1:0] repl [9];
  logic signed [PIXEL_BITS-1:0] newcol [3];
  logic signed [PIXEL_BITS-1:0] mid, top;
  logic                         f_valid, f_last, f_done;
  logic [COL_W-1:0]             f_col;
  logic signed [PIXEL_BITS-1:0] f_win [9];

  always_comb begin
    if (b_pix_r) begin
      mid = b_par_r ? d0 : d1;
      top = b_low_r ? mid : (b_par_r ? d1 : d0);
      newcol[2] = b_px_r;
    end else begin
      mid = b_par_r ? d1 : d0;
      top = b_par_r ? d0 : d1;
      newcol[2] = mid;
    end
    newcol[0] = top;
    newcol[1] = mid;
    for (int i = 0; i < 3; i++) begin
      if (b_triple_r) begin
        loaded[i*3+0] = newcol[i];
        loaded[i*3+1] = newcol[i];
      end else begin
        loaded[i*3+0] = win_r[i*3+1];
        loaded[i*3+1] = win_r[i*3+2];
      end
      loaded[i*3+2] = newcol[i];
      repl[i*3+0]   = win_r[i*3+1];
      repl[i*3+1]   = win_r[i*3+2];
      repl[i*3+2]   = win_r[i*3+2];
    end

    win_nxt      = win_r;
    f_win        = loaded;
    f_valid      = 1'b0;
    f_last       = 1'b1;
    f_done       = 1'b0;
    f_col        = b_col1_r;
    b_second_nxt = 1'b0;
    b_valid_nxt  = a_go;
    if (b_valid_r && b_second_r) begin
      // Second result of a row end: the right-hand column is replicated.
      win_nxt = repl;
      f_win   = repl;
      f_valid = 1'b1;
      f_col   = b_col2_r;
      f_done  = !b_pix_r;
    end else if (b_valid_r) begin
      if (b_load_r) begin
        win_nxt = loaded;
      end
      f_valid      = b_e1_r;
      f_last       = !b_e2_r;
      b_second_nxt = b_e2_r;
      b_valid_nxt  = a_go || b_e2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 9; j++) begin
        win_r[j] <= '0;
      end
    end else begin
      win_r <= win_nxt;
    end
  end

  logic                  fo_valid;
  logic [PIXEL_BITS-1:0] fo_value;
  logic [META_W-1:0]     fo_meta;

  rf3_filter #(.PIXEL_BITS(PIXEL_BITS), .META_W(META_W)) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_win    (f_win),
    .in_meta   ({f_done, f_last, b_row_r, f_col}),
    .mode      (mode_r),
    .out_valid (fo_valid),
    .out_value (fo_value),
    .out_meta  (fo_meta)
  );

  // Result queue; room is reserved at input transfer, so it never overflows.
  logic [FW-1:0]         q_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FW-1:0]         head;

  assign out_valid = cnt_r != '0;
  assign out_xfer  = out_valid && !out_stall;
  assign head      = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (fo_valid) wp_r <= wp_r + 1'b1;
      if (out_xfer) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + FIFO_CNT_W'(fo_valid) - FIFO_CNT_W'(out_xfer);
    end
    if (fo_valid) begin
      q_mem_r[wp_r] <= {fo_value, fo_meta};
    end
  end

  assign out_filtered_value = head[FW-1:META_W];
  assign out_frame_done     = head[META_W-1];
  assign out_last_of_item   = head[META_W-2];
  assign out_row            = head[COL_W+ROW_W-1:COL_W];
  assign out_column         = head[COL_W-1:0];

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("reserved queue room exceeds the queue depth");

  a_cnt_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= occ_r)
    else $error("queued results exceed the reservation");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fo_valid |-> cnt_r < FIFO_CNT_W'(FIFO_DEPTH) || out_xfer)
    else $error("result written into a full queue");

  a_second_once: assert property (@(posedge clk) disable iff (!rst_n)
    b_second_r |=> !b_second_r)
    else $error("replicated-column result repeated");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    b_second_nxt && b_valid_r && !b_second_r |-> !a_go)
    else $error("item transferred while a row end is still being emitted");

endmodule

// ----- test/rf3_checker.sv -----
// Scoreboard for the 3x3 rank filter: predicts results from observed transfers and compares them.
`timescale 1ns / 100ps

module rf3_checker
  import rf3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_command,
  input  logic signed [15:0]     in_pixel_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic signed [15:0]     out_filtered_value,
  input  logic [9:0]             out_column,
  input  logic [ROW_W-1:0]       out_row,
  input  logic                   out_frame_done,
  input  logic                   out_last_of_item,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic signed [15:0] value;
    logic [9:0]         column;
    logic [ROW_W-1:0]   row;
    logic               done;
    logic               last;
  } pixel_result_t;

  pixel_result_t expected_q[$];

  int    prior_rows [0:2047];
  int    win [0:8];
  int    next_col, next_row, flush_pos;
  int    width_reg, height_reg;
  mode_t mode_reg;
  int    mismatches;

  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > 1024) return 1024;
    return width_reg;
  endfunction

  function automatic int eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int row_slot(int r, int c);
    return (r % 2) * 1024 + (c % 1024);
  endfunction

  task automatic shift_column(int t, int m, int b);
    int col [0:2];
    col[0] = t; col[1] = m; col[2] = b;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
      win[i*3+2] = col[i];
    end
  endtask

  task automatic load_column(int k, int t, int m, int b);
    if (k == 0) begin
      shift_column(t, m, b);
      shift_column(t, m, b);
    end
    shift_column(t, m, b);
  endtask

  function automatic int rank_of_window();
    int a [0:8];
    int tmp, s, x;
    for (int i = 0; i < 9; i++) a[i] = win[i];
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8 - i; j++)
        if (a[j] > a[j+1]) begin
          tmp = a[j]; a[j] = a[j+1]; a[j+1] = tmp;
        end
    if (mode_reg == MODE_WINSOR) begin
      x = win[4];
      if (x < a[2]) x = a[2];
      else if (x > a[6]) x = a[6];
      return x;
    end
    if (mode_reg == MODE_WEIGHTED) begin
      s = a[2] + a[6] + 2 * (a[3] + a[5]) + 4 * a[4];
      if (s >= 0) return (s + 5) / 10;
      return -((-s + 5) / 10);
    end
    return a[4];
  endfunction

  task automatic predict_item(logic cmd, int px);
    pixel_result_t res [0:1];
    int n, w, k, r, c, t, m;
    n = 0;
    w = eff_width();
    if (cmd) begin
      if (flush_pos == 0) return;
      k = flush_pos - 1;
      r = next_row;
      m = prior_rows[row_slot(r, k)];
      t = (r >= 1) ? prior_rows[row_slot(r - 1, k)] : m;
      load_column(k, t, m, m);
      if (k >= 1) begin
        res[n] = '{rank_of_window(), k - 1, r, 1'b0, 1'b0};
        n++;
      end
      if (k >= w - 1) begin
        shift_column(win[2], win[5], win[8]);
        res[n] = '{rank_of_window(), k, r, 1'b1, 1'b0};
        n++;
        flush_pos = 0;
        next_row = 0;
        next_col = 0;
      end else begin
        flush_pos++;
      end
    end else begin
      if (flush_pos != 0) return;
      r = next_row;
      c = next_col;
      if (r >= 1) begin
        m = prior_rows[row_slot(r - 1, c)];
        t = (r >= 2) ? prior_rows[row_slot(r, c)] : m;
        load_column(c, t, m, px);
        if (c >= 1) begin
          res[n] = '{rank_of_window(), c - 1, r - 1, 1'b0, 1'b0};
          n++;
        end
        if (c >= w - 1) begin
          shift_column(win[2], win[5], win[8]);
          res[n] = '{rank_of_window(), c, r - 1, 1'b0, 1'b0};
          n++;
        end
      end
      prior_rows[row_slot(r, c)] = px;
      if (c >= w - 1) begin
        next_col = 0;
        if (r >= eff_height() - 1) flush_pos = 1;
        else next_row = r + 1;
      end else begin
        next_col = c + 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      expected_q.push_back(res[i]);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
    for (int i = 0; i < 2048; i++) prior_rows[i] = 0;
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win[i] = 0;
      next_col   = 0;
      next_row   = 0;
      flush_pos  = 0;
      width_reg  = 1024;
      height_reg = 1024;
      mode_reg   = MODE_MEDIAN;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result value %0d col %0d row %0d", $realtime,
                     out_filtered_value, out_column, out_row);
        end else begin
          want = expected_q.pop_front();
          if (out_filtered_value !== want.value || out_column !== want.column ||
              out_row !== want.row || out_frame_done !== want.done ||
              out_last_of_item !== want.last) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected val %0d col %0d row %0d done %0b last %0b, got %0d %0d %0d %0b %0b",
                       $realtime, want.value, want.column, want.row, want.done, want.last,
                       out_filtered_value, out_column, out_row, out_frame_done,
                       out_last_of_item);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data[WIDTH_REG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          CFG_FILTER_MODE:  mode_reg   = mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_item(in_command, int'(in_pixel_value));
    end
    pending <= expected_q.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the 3x3 rank filter testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import rf3_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_command;
  logic signed [15:0]     in_pixel_value;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [15:0]     out_filtered_value;
  logic [9:0]             out_column;
  logic [ROW_W-1:0]       out_row;
  logic                   out_frame_done;
  logic                   out_last_of_item;

  int fail_count;
  int pending;
  int cycle_count;
  int items_sent;
  int burst_left;
  bit hold_request;

  localparam int CYCLE_LIMIT = 2000000;

  rank_filter_3x3 DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_column         (out_column),
    .out_row            (out_row),
    .out_frame_done     (out_frame_done),
    .out_last_of_item   (out_last_of_item)
  );

  rf3_checker scoreboard (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_column         (out_column),
    .out_row            (out_row),
    .out_frame_done     (out_frame_done),
    .out_last_of_item   (out_last_of_item),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts every clock cycle; running past the limit means something has hung.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rank_filter_3x3] ERROR");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: free-running stretches, random stalls and a
  // regular duty cycle. Once, on request, it holds off for a long stretch so that the result
  // queue fills up and the block must stall its input while the sender keeps offering.
  initial begin
    int style, span;
    out_stall = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (int i = 0; i < 300; i++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      style = $urandom_range(0, 2);
      span  = $urandom_range(5, 60);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= (i % 4 == 3);
        endcase
      end
    end
  end

  // One transfer on the input channel. The sender works in bursts separated by random gaps;
  // valid stays high across back-to-back transfers within a burst.
  task automatic send_item(logic cmd, logic signed [15:0] px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_pixel_value <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Pixel values are drawn so that ties, extremes and ordinary noise all turn up.
  function automatic logic signed [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      3: return 16'sh7FFF - 16'($urandom_range(0, 20));
      4: return 16'sh8000 + 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // Wait until every expected result has arrived, then let the pipeline settle so that
  // items which caused no result have certainly left the block.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers are only written while the block is idle, between frames.
  task automatic configure(int w, int h, int mode);
    wait_until_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_FILTER_MODE, mode);
  endtask

  // One full frame followed by its flush. With noise on, stray flushes arrive while no flush
  // is pending and stray pixels arrive while one is; the block must ignore both.
  task automatic run_frame(int w_raw, int h_raw, bit noisy);
    int w, h;
    w = (w_raw < 3) ? 3 : (w_raw > 1024) ? 1024 : w_raw;
    h = (h_raw < 3) ? 3 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(1'b1, 16'($urandom));
      send_item(1'b0, pick_pixel());
    end
    for (int k = 0; k < w; k++) begin
      if (noisy && $urandom_range(0, 4) == 0) send_item(1'b0, pick_pixel());
      send_item(1'b1, 16'($urandom));
    end
  endtask

  initial begin
    int w, h;
    hold_request   = 1'b0;
    burst_left     = 0;
    items_sent     = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IMAGE_WIDTH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_command     = 1'b0;
    in_pixel_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frame: width and height below range clamp to three, median mode, with a
    // flush that arrives when none is pending and a pixel that arrives while one is.
    configure(0, 0, MODE_MEDIAN);
    send_item(1'b1, 16'sh1234);
    send_item(1'b0, 16'sh8000);
    send_item(1'b0, 16'sh7FFF);
    send_item(1'b0, 16'sh0000);
    send_item(1'b0, 16'shFFFF);
    send_item(1'b0, 16'sh8000);
    send_item(1'b0, 16'sh7FFF);
    send_item(1'b0, 16'sh0001);
    send_item(1'b0, 16'sh8000);
    send_item(1'b0, 16'sh7FFF);
    send_item(1'b0, 16'sh5555);
    send_item(1'b1, 16'sh0000);
    send_item(1'b1, 16'shFFFF);
    send_item(1'b1, 16'sh0000);

    // A wider, short frame in weighted mode while the receiver holds off for a long stretch.
    configure(100, 3, MODE_WEIGHTED);
    hold_request = 1'b1;
    run_frame(100, 3, 1'b0);

    // Every mode in turn on a small frame, the unused mode included.
    for (int mode = 0; mode < 4; mode++) begin
      configure(4, 5, mode);
      run_frame(4, 5, 1'b1);
    end

    while (items_sent < 1400) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      configure(w, h, $urandom_range(0, 3));
      repeat ($urandom_range(1, 2)) run_frame(w, h, $urandom_range(0, 1));
    end

    wait_until_idle();
    if (fail_count == 0) begin
      $display("[rank_filter_3x3] OK");
    end else begin
      $display("[rank_filter_3x3] ERROR");
    end
    $finish;
  end

endmodule
